// ===== rtl/mcog_pkg.sv =====
// ----------------------------------------------------------------------------
// mcog_pkg
// Shared constants and controller/datapath interface types for the midpoint
// circle outline generator.
// ----------------------------------------------------------------------------
package mcog_pkg;

    localparam int COORD_BITS_DEF = 11;
    localparam int PIX_BITS       = 14;
    localparam int COLOR_BITS     = 8;
    localparam int IDX_BITS       = 3;

    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    localparam logic [IDX_BITS-1:0] IDX_LAST = 3'd7;

    typedef struct packed {
        logic                load;
        logic                square;
        logic                sum;
        logic                root_step;
        logic                walk_init;
        logic                emit;
        logic                step;
        logic [IDX_BITS-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic finished;
    } t_stat;

endpackage

// ===== rtl/mcog_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcog_ctrl
// Sequencer: load/square/sum/root/walk-init phases, then serial emission of
// the eight mirrored pixels of one octant step into the output register.
// ----------------------------------------------------------------------------
module mcog_ctrl #(
    parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_req_type,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output mcog_pkg::t_cmd o_cmd,
    input  mcog_pkg::t_stat i_stat
);

    localparam int CW = $clog2(COORD_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_WALK_INIT,
        S_EMIT
    } t_state;

    t_state                      r_state;
    logic                        r_active;
    logic [CW-1:0]               r_cnt;
    logic [mcog_pkg::IDX_BITS-1:0] r_idx;
    logic                        r_out_valid;

    logic in_fire;
    logic out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.idx       = r_idx;
        o_cmd.load      = in_fire && (i_req_type == mcog_pkg::REQ_LOAD);
        o_cmd.square    = (r_state == S_SQUARE);
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.root_step = (r_state == S_ROOT);
        o_cmd.walk_init = (r_state == S_WALK_INIT);
        o_cmd.emit      = (r_state == S_EMIT) && out_free;
        o_cmd.step      = o_cmd.emit && (r_idx == mcog_pkg::IDX_LAST);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= 1'b0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_req_type == mcog_pkg::REQ_LOAD) begin
                            r_active <= 1'b0;
                            r_state  <= S_SQUARE;
                        end else if (r_active) begin
                            r_idx   <= '0;
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_SQUARE: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_cnt   <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(COORD_BITS)) begin
                        r_state <= S_WALK_INIT;
                    end
                end
                S_WALK_INIT: begin
                    r_active <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_EMIT: begin
                    if (o_cmd.emit) begin
                        r_idx <= r_idx + 1'b1;
                        if (o_cmd.step) begin
                            if (i_stat.finished) begin
                                r_active <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_idx_only_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (r_state == S_EMIT))
        else $error("pixel index nonzero outside emission");

    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_req_type == mcog_pkg::REQ_ADVANCE) && !r_active)
        |=> (r_state == S_IDLE))
        else $error("advance without circle left idle");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_stat.finished) |=> !r_active)
        else $error("final step did not end the circle");

    a_init_activates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_INIT) |=> (r_active && (r_state == S_IDLE)))
        else $error("walk init did not activate circle");

endmodule

// ===== rtl/mcog_dp.sv =====
// ----------------------------------------------------------------------------
// mcog_dp
// Datapath: centre/colour latches, squared distance, bit-serial integer
// square root, octant walk registers and the output word register.
// ----------------------------------------------------------------------------
module mcog_dp #(
    parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEF
) (
    input  logic                                   i_clk,
    input  mcog_pkg::t_cmd                         i_cmd,
    output mcog_pkg::t_stat                        o_stat,
    input  logic [COORD_BITS-1:0]                  i_center_x,
    input  logic [COORD_BITS-1:0]                  i_center_y,
    input  logic [COORD_BITS-1:0]                  i_edge_x,
    input  logic [COORD_BITS-1:0]                  i_edge_y,
    input  logic [mcog_pkg::COLOR_BITS-1:0]        i_color_red,
    input  logic [mcog_pkg::COLOR_BITS-1:0]        i_color_green,
    input  logic [mcog_pkg::COLOR_BITS-1:0]        i_color_blue,
    output logic signed [mcog_pkg::PIX_BITS-1:0]   o_pixel_x,
    output logic signed [mcog_pkg::PIX_BITS-1:0]   o_pixel_y,
    output logic [mcog_pkg::COLOR_BITS-1:0]        o_out_red,
    output logic [mcog_pkg::COLOR_BITS-1:0]        o_out_green,
    output logic [mcog_pkg::COLOR_BITS-1:0]        o_out_blue,
    output logic                                   o_step_last,
    output logic                                   o_circle_done
);

    localparam int CB = COORD_BITS;
    localparam int SW = 2 * CB;
    localparam int N  = 2 * CB + 2;
    localparam int OW = CB + 2;
    localparam int DW = CB + 4;
    localparam int PW = (mcog_pkg::PIX_BITS > CB + 3) ? mcog_pkg::PIX_BITS : CB + 3;

    logic [CB-1:0]                   r_cx, r_cy;
    logic [CB-1:0]                   r_ax, r_ay;
    logic [SW-1:0]                   r_sqx, r_sqy;
    logic [N-1:0]                    r_v, r_root, r_bit;
    logic signed [OW-1:0]            r_x, r_y;
    logic signed [DW-1:0]            r_d;
    logic [mcog_pkg::COLOR_BITS-1:0] r_red, r_green, r_blue;
    logic [mcog_pkg::PIX_BITS-1:0]   r_px, r_py;
    logic [mcog_pkg::COLOR_BITS-1:0] r_ored, r_ogreen, r_oblue;
    logic                            r_last, r_done;

    logic [N-1:0]         trial;
    logic                 fits;
    logic signed [OW-1:0] y1, x1;
    logic                 d_neg;
    logic signed [DW-1:0] n_d;
    logic signed [OW-1:0] a_sel, b_sel;
    logic signed [PW-1:0] cx_e, cy_e, a_e, b_e, px_w, py_w;

    assign trial = r_root + r_bit;
    assign fits  = (r_v >= trial);

    assign y1    = r_y + OW'(1);
    assign d_neg = r_d[DW-1];
    assign x1    = d_neg ? r_x : r_x - OW'(1);
    assign n_d   = d_neg ? r_d + (DW'(y1) <<< 1) + DW'(1)
                         : r_d + ((DW'(y1) - DW'(x1) + DW'(1)) <<< 1);
    assign o_stat.finished = (x1 < y1);

    // idx[0] swaps x/y, idx[1]^idx[2] negates x term, idx[2] negates y term
    assign a_sel = i_cmd.idx[0] ? r_y : r_x;
    assign b_sel = i_cmd.idx[0] ? r_x : r_y;
    assign cx_e  = signed'(PW'(r_cx));
    assign cy_e  = signed'(PW'(r_cy));
    assign a_e   = PW'(a_sel);
    assign b_e   = PW'(b_sel);
    assign px_w  = (i_cmd.idx[1] ^ i_cmd.idx[2]) ? cx_e - a_e : cx_e + a_e;
    assign py_w  = i_cmd.idx[2] ? cy_e - b_e : cy_e + b_e;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx    <= i_center_x;
            r_cy    <= i_center_y;
            r_ax    <= (i_edge_x >= i_center_x) ? i_edge_x - i_center_x
                                                : i_center_x - i_edge_x;
            r_ay    <= (i_edge_y >= i_center_y) ? i_edge_y - i_center_y
                                                : i_center_y - i_edge_y;
            r_red   <= i_color_red;
            r_green <= i_color_green;
            r_blue  <= i_color_blue;
        end
        if (i_cmd.square) begin
            r_sqx <= SW'(r_ax) * SW'(r_ax);
            r_sqy <= SW'(r_ay) * SW'(r_ay);
        end
        if (i_cmd.sum) begin
            r_v    <= N'(r_sqx) + N'(r_sqy);
            r_root <= '0;
            r_bit  <= {2'b01, {(N-2){1'b0}}};
        end
        if (i_cmd.root_step) begin
            if (fits) begin
                r_v    <= r_v - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.walk_init) begin
            r_x <= signed'({1'b0, r_root[CB:0]});
            r_y <= '0;
            r_d <= DW'(1) - signed'(DW'(r_root[CB:0]));
        end
        if (i_cmd.step) begin
            r_x <= x1;
            r_y <= y1;
            r_d <= n_d;
        end
        if (i_cmd.emit) begin
            r_px     <= px_w[mcog_pkg::PIX_BITS-1:0];
            r_py     <= py_w[mcog_pkg::PIX_BITS-1:0];
            r_ored   <= r_red;
            r_ogreen <= r_green;
            r_oblue  <= r_blue;
            r_last   <= (i_cmd.idx == mcog_pkg::IDX_LAST);
            r_done   <= (i_cmd.idx == mcog_pkg::IDX_LAST) && o_stat.finished;
        end
    end

    assign o_pixel_x     = signed'(r_px);
    assign o_pixel_y     = signed'(r_py);
    assign o_out_red     = r_ored;
    assign o_out_green   = r_ogreen;
    assign o_out_blue    = r_oblue;
    assign o_step_last   = r_last;
    assign o_circle_done = r_done;

endmodule

// ===== rtl/midpoint_circle_outline_generator.sv =====
// ----------------------------------------------------------------------------
// midpoint_circle_outline_generator
// Midpoint circle rasterizer with 8-way symmetry, one octant step per advance.
// ----------------------------------------------------------------------------
// A load word (req_type 0) latches centre, colour and the absolute offsets of
// the edge point and produces no output; the radius comes from a bit-serial
// square root of dx^2+dy^2, one root bit per cycle, and the block is not ready
// while it steps through the square, sum, root and walk-init states. An advance
// word (req_type 1) on an active circle emits eight pixel words, one per cycle
// while the output is drained, and the block takes the next word once the
// eighth is emitted. An advance with no active circle is taken and emits
// nothing. The last pixel of each step carries step_last, and the last of the
// circle also circle_done. A new input word is accepted while the final pixel
// still waits in the output register.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_generator #(
    parameter int COORD_BITS = mcog_pkg::COORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_req_type,
    input  logic [COORD_BITS-1:0]                i_center_x,
    input  logic [COORD_BITS-1:0]                i_center_y,
    input  logic [COORD_BITS-1:0]                i_edge_x,
    input  logic [COORD_BITS-1:0]                i_edge_y,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_red,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_green,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_blue,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [mcog_pkg::PIX_BITS-1:0] o_pixel_x,
    output logic signed [mcog_pkg::PIX_BITS-1:0] o_pixel_y,
    output logic [mcog_pkg::COLOR_BITS-1:0]      o_out_red,
    output logic [mcog_pkg::COLOR_BITS-1:0]      o_out_green,
    output logic [mcog_pkg::COLOR_BITS-1:0]      o_out_blue,
    output logic                                 o_step_last,
    output logic                                 o_circle_done
);

    mcog_pkg::t_cmd  cmd;
    mcog_pkg::t_stat stat;

    mcog_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    mcog_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_edge_x      (i_edge_x),
        .i_edge_y      (i_edge_y),
        .i_color_red   (i_color_red),
        .i_color_green (i_color_green),
        .i_color_blue  (i_color_blue),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_step_last   (o_step_last),
        .o_circle_done (o_circle_done)
    );

endmodule

// ===== sim/midpoint_circle_outline_generator_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline_generator_chk
// Watches both channels of the circle outline generator, keeps its own
// midpoint walk per accepted request word and compares every pixel word
// field by field against the oldest pixel still owed.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_generator_chk (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic                                 i_req_type,
    input  logic [mcog_pkg::COORD_BITS_DEF-1:0]  i_center_x,
    input  logic [mcog_pkg::COORD_BITS_DEF-1:0]  i_center_y,
    input  logic [mcog_pkg::COORD_BITS_DEF-1:0]  i_edge_x,
    input  logic [mcog_pkg::COORD_BITS_DEF-1:0]  i_edge_y,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_red,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_green,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_color_blue,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic signed [mcog_pkg::PIX_BITS-1:0] i_pixel_x,
    input  logic signed [mcog_pkg::PIX_BITS-1:0] i_pixel_y,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_out_red,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_out_green,
    input  logic [mcog_pkg::COLOR_BITS-1:0]      i_out_blue,
    input  logic                                 i_step_last,
    input  logic                                 i_circle_done,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    typedef struct {
        logic signed [mcog_pkg::PIX_BITS-1:0] px;
        logic signed [mcog_pkg::PIX_BITS-1:0] py;
        logic [mcog_pkg::COLOR_BITS-1:0]      red;
        logic [mcog_pkg::COLOR_BITS-1:0]      green;
        logic [mcog_pkg::COLOR_BITS-1:0]      blue;
        logic                                 last;
        logic                                 done;
    } t_pixel_word;

    t_pixel_word owed_pixels[$];

    int                              centre_x;
    int                              centre_y;
    int                              walk_x;
    int                              walk_y;
    int                              decision;
    bit                              walking;
    logic [mcog_pkg::COLOR_BITS-1:0] pen_red;
    logic [mcog_pkg::COLOR_BITS-1:0] pen_green;
    logic [mcog_pkg::COLOR_BITS-1:0] pen_blue;
    int                              errors = 0;

    function automatic int floor_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 15; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
        end
        return int'(root);
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic plot_request();
        int dx;
        int dy;
        int x;
        int y;
        int cx_list[8];
        int cy_list[8];
        bit finished;
        t_pixel_word w;
        if (i_req_type == mcog_pkg::REQ_LOAD) begin
            centre_x  = int'(i_center_x);
            centre_y  = int'(i_center_y);
            dx        = int'(i_edge_x) - centre_x;
            dy        = int'(i_edge_y) - centre_y;
            walk_x    = floor_sqrt(longint'(dx * dx + dy * dy));
            walk_y    = 0;
            decision  = 1 - walk_x;
            pen_red   = i_color_red;
            pen_green = i_color_green;
            pen_blue  = i_color_blue;
            walking   = 1'b1;
            return;
        end
        if (!walking) return;
        x = walk_x;
        y = walk_y;
        cx_list = '{centre_x + x, centre_x + y, centre_x - x, centre_x - y,
                    centre_x - x, centre_x - y, centre_x + x, centre_x + y};
        cy_list = '{centre_y + y, centre_y + x, centre_y + y, centre_y + x,
                    centre_y - y, centre_y - x, centre_y - y, centre_y - x};
        y = y + 1;
        if (decision < 0) begin
            decision += 2 * y + 1;
        end else begin
            x = x - 1;
            decision += 2 * (y - x + 1);
        end
        walk_x   = x;
        walk_y   = y;
        finished = (x < y);
        if (finished) walking = 1'b0;
        for (int k = 0; k < 8; k++) begin
            w.px    = cx_list[k][mcog_pkg::PIX_BITS-1:0];
            w.py    = cy_list[k][mcog_pkg::PIX_BITS-1:0];
            w.red   = pen_red;
            w.green = pen_green;
            w.blue  = pen_blue;
            w.last  = (k == int'(mcog_pkg::IDX_LAST));
            w.done  = (k == int'(mcog_pkg::IDX_LAST)) && finished;
            owed_pixels.push_back(w);
        end
    endtask

    task automatic check_pixel();
        t_pixel_word want;
        if (owed_pixels.size() == 0) begin
            flag_mismatch($sformatf("unexpected pixel word x=%0d y=%0d",
                                    i_pixel_x, i_pixel_y));
            return;
        end
        want = owed_pixels.pop_front();
        check_field("pixel_x", int'(i_pixel_x), int'(want.px));
        check_field("pixel_y", int'(i_pixel_y), int'(want.py));
        check_field("out_red", int'(i_out_red), int'(want.red));
        check_field("out_green", int'(i_out_green), int'(want.green));
        check_field("out_blue", int'(i_out_blue), int'(want.blue));
        check_field("step_last", int'(i_step_last), int'(want.last));
        check_field("circle_done", int'(i_circle_done), int'(want.done));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            centre_x  = 0;
            centre_y  = 0;
            walk_x    = 0;
            walk_y    = 0;
            decision  = 0;
            walking   = 1'b0;
            pen_red   = '0;
            pen_green = '0;
            pen_blue  = '0;
            owed_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_pixel();
            if (i_in_valid && i_in_ready) plot_request();
        end
        o_pending    <= owed_pixels.size();
        o_fail_count <= errors;
    end

endmodule

// ===== sim/midpoint_circle_outline_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midpoint_circle_outline_generator_tb
// Drives load and advance words into the circle outline generator: a directed
// set of edge cases, then random circles, mostly small and walked to the end,
// under several idle and stall mixes plus one long output hold-off. The
// checker beside the block scores every pixel word.
// ----------------------------------------------------------------------------
module midpoint_circle_outline_generator_tb;

    localparam int CW = mcog_pkg::COORD_BITS_DEF;
    localparam int KW = mcog_pkg::COLOR_BITS;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 i_in_valid;
    logic                                 o_in_ready;
    logic                                 i_req_type;
    logic [CW-1:0]                        i_center_x;
    logic [CW-1:0]                        i_center_y;
    logic [CW-1:0]                        i_edge_x;
    logic [CW-1:0]                        i_edge_y;
    logic [KW-1:0]                        i_color_red;
    logic [KW-1:0]                        i_color_green;
    logic [KW-1:0]                        i_color_blue;
    logic                                 o_out_valid;
    logic                                 i_out_ready = 1'b0;
    logic signed [mcog_pkg::PIX_BITS-1:0] o_pixel_x;
    logic signed [mcog_pkg::PIX_BITS-1:0] o_pixel_y;
    logic [KW-1:0]                        o_out_red;
    logic [KW-1:0]                        o_out_green;
    logic [KW-1:0]                        o_out_blue;
    logic                                 o_step_last;
    logic                                 o_circle_done;

    int fail_count;
    int pending;
    int idle_pct   = 0;
    int stall_pct  = 0;
    int hold_left  = 0;
    bit hold_arm   = 1'b0;
    bit hold_used  = 1'b0;
    int words_sent = 0;

    midpoint_circle_outline_generator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_edge_x      (i_edge_x),
        .i_edge_y      (i_edge_y),
        .i_color_red   (i_color_red),
        .i_color_green (i_color_green),
        .i_color_blue  (i_color_blue),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_out_red     (o_out_red),
        .o_out_green   (o_out_green),
        .o_out_blue    (o_out_blue),
        .o_step_last   (o_step_last),
        .o_circle_done (o_circle_done)
    );

    midpoint_circle_outline_generator_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_edge_x      (i_edge_x),
        .i_edge_y      (i_edge_y),
        .i_color_red   (i_color_red),
        .i_color_green (i_color_green),
        .i_color_blue  (i_color_blue),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pixel_x     (o_pixel_x),
        .i_pixel_y     (o_pixel_y),
        .i_out_red     (o_out_red),
        .i_out_green   (o_out_green),
        .i_out_blue    (o_out_blue),
        .i_step_last   (o_step_last),
        .i_circle_done (o_circle_done),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // output side: random stalls, one long hold-off once armed
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_arm && !hold_used) begin
            i_out_ready <= 1'b0;
            hold_left   <= 400;
            hold_used   <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_word(input logic rtype,
                             input logic [CW-1:0] cx, cy, ex, ey,
                             input logic [KW-1:0] r, g, b);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= rtype;
        i_center_x    <= cx;
        i_center_y    <= cy;
        i_edge_x      <= ex;
        i_edge_y      <= ey;
        i_color_red   <= r;
        i_color_green <= g;
        i_color_blue  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
    endtask

    // advance words carry random junk in the load-only fields
    task automatic send_advance();
        send_word(mcog_pkg::REQ_ADVANCE, CW'($urandom_range(2047)),
                  CW'($urandom_range(2047)), CW'($urandom_range(2047)),
                  CW'($urandom_range(2047)), KW'($urandom_range(255)),
                  KW'($urandom_range(255)), KW'($urandom_range(255)));
    endtask

    task automatic send_circle(input logic [CW-1:0] cx, cy, ex, ey,
                               input logic [KW-1:0] r, g, b,
                               input int steps);
        send_word(mcog_pkg::REQ_LOAD, cx, cy, ex, ey, r, g, b);
        repeat (steps) send_advance();
    endtask

    function automatic logic [CW-1:0] offset_coord(
            input logic [CW-1:0] c, input int d);
        int v;
        v = int'(c) + d;
        if (v < 0 || v > 2047) v = int'(c) - d;
        return v[CW-1:0];
    endfunction

    task automatic random_circle();
        logic [CW-1:0] cx;
        logic [CW-1:0] cy;
        logic [CW-1:0] ex;
        logic [CW-1:0] ey;
        int dx;
        int dy;
        int steps;
        cx = CW'($urandom_range(2047));
        cy = CW'($urandom_range(2047));
        if ($urandom_range(99) < 5) send_advance();
        if ($urandom_range(99) < 10) begin
            // big circle, abandoned after a few steps
            ex    = CW'($urandom_range(2047));
            ey    = CW'($urandom_range(2047));
            steps = $urandom_range(3, 1);
        end else begin
            dx    = int'($urandom_range(24)) - 12;
            dy    = int'($urandom_range(24)) - 12;
            ex    = offset_coord(cx, dx);
            ey    = offset_coord(cy, dy);
            dx    = (dx < 0) ? -dx : dx;
            dy    = (dy < 0) ? -dy : dy;
            steps = ((dx > dy) ? dx : dy) + 1;
            if ($urandom_range(99) < 20) steps = $urandom_range(steps);
        end
        send_circle(cx, cy, ex, ey, KW'($urandom_range(255)), KW'($urandom_range(255)),
                    KW'($urandom_range(255)), steps);
        if ($urandom_range(99) < 10) send_advance();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_req_type    <= mcog_pkg::REQ_LOAD;
        i_center_x    <= '0;
        i_center_y    <= '0;
        i_edge_x      <= '0;
        i_edge_y      <= '0;
        i_color_red   <= '0;
        i_color_green <= '0;
        i_color_blue  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray advance, zero radius, extreme corners, small walk
        send_advance();
        send_circle(11'd1000, 11'd1000, 11'd1000, 11'd1000, 8'hFF, 8'h00, 8'h00, 2);
        send_circle(11'd0, 11'd0, 11'd2047, 11'd2047, 8'h00, 8'hFF, 8'h00, 2);
        send_circle(11'd2047, 11'd2047, 11'd0, 11'd0, 8'h00, 8'h00, 8'hFF, 2);
        send_circle(11'd2047, 11'd0, 11'd0, 11'd2047, 8'hFF, 8'hFF, 8'hFF, 1);
        send_circle(11'd100, 11'd100, 11'd103, 11'd104, 8'h55, 8'hAA, 8'h5A, 5);
        send_circle(11'd0, 11'd2047, 11'd1, 11'd2047, 8'hA5, 8'h3C, 8'hC3, 2);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 65; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 65; end
                3: begin idle_pct = 6;  stall_pct <= 6;  end
                default: begin
                    idle_pct  = 0;
                    stall_pct <= 0;
                    hold_arm  <= 1'b1;
                end
            endcase
            words_sent = 0;
            while (words_sent < 18) random_circle();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
